// ----- hw/rtl/tsmf_pkg.sv -----
// Shared widths, codes and types for the touch sample filter.
`default_nettype none
package tsmf_pkg;

  localparam int REPLY_W    = 16;
  localparam int SAMPLE_W   = 13;
  localparam int SUM_W      = 15;
  localparam int MEAN_W     = 14;
  localparam int THR_W      = 13;
  localparam int POS_W      = 13;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 4;
  localparam int NUM_GROUPS = 3;
  localparam int SHIFT      = 3;

  localparam logic [COUNT_W-1:0] LAST_PAIR  = 4'd8;
  localparam logic [COUNT_W-1:0] GRP1_FIRST = 4'd3;
  localparam logic [COUNT_W-1:0] GRP2_FIRST = 4'd6;

  // floor(s/3) == (s * 21846) >> 16 for every 15-bit s
  localparam logic [SUM_W-1:0] RECIP3   = 15'd21846;
  localparam int               RECIP_SH = 16;

  localparam logic [THR_W-1:0] THR_RESET = 13'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PEN_UP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_X_BAD  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_Y_BAD  = 2'd3;

  typedef logic [NUM_GROUPS-1:0][SUM_W-1:0] sum_arr_t;

  typedef struct packed {
    logic start;
  } axis_ctl_t;

  typedef struct packed {
    logic             done;
    logic             reject;
    logic [POS_W-1:0] pos;
  } axis_res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tsmf_ifs.sv -----
// Valid/ready channel interfaces for sample pairs, results and configuration.
`default_nettype none
interface tsmf_in_if;
  import tsmf_pkg::*;
  logic                valid;
  logic                ready;
  logic [REPLY_W-1:0]  x_reply;
  logic [REPLY_W-1:0]  y_reply;
  logic                pen_down;
  modport source (output valid, x_reply, y_reply, pen_down, input ready);
  modport sink   (input valid, x_reply, y_reply, pen_down, output ready);
endinterface

interface tsmf_out_if;
  import tsmf_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    x_pos;
  logic [POS_W-1:0]    y_pos;
  modport source (output valid, status, x_pos, y_pos, input ready);
  modport sink   (input valid, status, x_pos, y_pos, output ready);
endinterface

interface tsmf_cfg_if;
  import tsmf_pkg::*;
  logic                valid;
  logic                ready;
  logic [THR_W-1:0]    reject_threshold;
  modport source (output valid, reject_threshold, input ready);
  modport sink   (input valid, reject_threshold, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tsmf_axis_eval.sv -----
// Shared per-axis evaluator: group means, spreads, reject test and closest-pair average.
`default_nettype none
module tsmf_axis_eval (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tsmf_pkg::axis_ctl_t              ctl,
  input  tsmf_pkg::sum_arr_t               sums,
  input  logic [tsmf_pkg::THR_W-1:0]       thr,
  output tsmf_pkg::axis_res_t              res
);
  import tsmf_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_DIV0 = 3'd1;
  localparam logic [2:0] P_DIV1 = 3'd2;
  localparam logic [2:0] P_DIV2 = 3'd3;
  localparam logic [2:0] P_DIFF = 3'd4;
  localparam logic [2:0] P_PICK = 3'd5;

  logic [2:0]            phase_r, phase_nxt;
  logic [MEAN_W-1:0]     g_r [NUM_GROUPS];
  logic [MEAN_W-1:0]     m_r [NUM_GROUPS];
  logic [SUM_W-1:0]      div_in;
  logic [2*SUM_W-1:0]    prod;
  logic [MEAN_W-1:0]     mean;
  logic [MEAN_W-1:0]     thr_ext;
  logic [MEAN_W:0]       pair_sum;
  logic                  reject;

  function automatic logic [MEAN_W-1:0] abs_diff(input logic [MEAN_W-1:0] a,
                                                 input logic [MEAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      P_IDLE:  if (ctl.start) phase_nxt = P_DIV0;
      P_DIV0:  phase_nxt = P_DIV1;
      P_DIV1:  phase_nxt = P_DIV2;
      P_DIV2:  phase_nxt = P_DIFF;
      P_DIFF:  phase_nxt = P_PICK;
      // a start in the pick cycle chains straight into the next axis
      P_PICK:  phase_nxt = ctl.start ? P_DIV0 : P_IDLE;
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // one reciprocal multiply per cycle, shared by the three groups
  always_comb begin
    case (phase_r)
      P_DIV1:  div_in = sums[1];
      P_DIV2:  div_in = sums[2];
      default: div_in = sums[0];
    endcase
    prod = div_in * RECIP3;
    mean = prod[RECIP_SH +: MEAN_W];
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      P_DIV0: g_r[0] <= mean;
      P_DIV1: g_r[1] <= mean;
      P_DIV2: g_r[2] <= mean;
      P_DIFF: begin
        m_r[0] <= abs_diff(g_r[0], g_r[1]);
        m_r[1] <= abs_diff(g_r[1], g_r[2]);
        m_r[2] <= abs_diff(g_r[2], g_r[0]);
      end
      default: ;
    endcase
  end

  // strict compares fix the tie order
  always_comb begin
    thr_ext = {{(MEAN_W-THR_W){1'b0}}, thr};
    reject  = (m_r[0] > thr_ext) && (m_r[1] > thr_ext) && (m_r[2] > thr_ext);
    if (m_r[0] < m_r[1]) begin
      if (m_r[2] < m_r[0]) pair_sum = {1'b0, g_r[0]} + {1'b0, g_r[2]};
      else                 pair_sum = {1'b0, g_r[0]} + {1'b0, g_r[1]};
    end else if (m_r[2] < m_r[1]) begin
      pair_sum = {1'b0, g_r[0]} + {1'b0, g_r[2]};
    end else begin
      pair_sum = {1'b0, g_r[1]} + {1'b0, g_r[2]};
    end
    res.done   = (phase_r == P_PICK);
    res.reject = reject;
    res.pos    = pair_sum[POS_W:1];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/touch_sample_median_filter.sv -----
// Touch filter: accumulates nine X/Y pairs, then one shared evaluator decides X and Y in turn.
// Throughput: one sample pair per cycle while a point fills and the spare is empty; the input holds
//   during a decision. After the ninth pair the evaluator runs X, then Y, through three multiplies,
//   the spread and the pick; an X reject ends the point after X; each result is then registered.
// An early pen release registers its result at the accepting edge; a spare output register takes
//   one result while another waits, so outside a decision the input holds only when both are full.
// Reset (synchronous, rst_n low) clears the point, both output registers and sets the threshold to 2.
`default_nettype none
module touch_sample_median_filter (
  input  logic       clk,
  input  logic       rst_n,
  tsmf_in_if.sink    in_ch,
  tsmf_out_if.source out_ch,
  tsmf_cfg_if.sink   cfg_ch
);
  import tsmf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_X    = 2'd1;
  localparam logic [1:0] S_Y    = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [COUNT_W-1:0]   pair_count_r, pair_count_nxt;
  sum_arr_t             x_sum_r, x_sum_nxt;
  sum_arr_t             y_sum_r, y_sum_nxt;
  logic [THR_W-1:0]     thr_r;
  logic [POS_W-1:0]     x_keep_r, x_keep_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [POS_W-1:0]     out_x_r, out_x_nxt;
  logic [POS_W-1:0]     out_y_r, out_y_nxt;
  logic                 spare_valid_r, spare_valid_nxt;
  logic [STATUS_W-1:0]  spare_status_r, spare_status_nxt;
  logic [POS_W-1:0]     spare_x_r, spare_x_nxt;
  logic [POS_W-1:0]     spare_y_r, spare_y_nxt;
  logic                 res_push;
  logic [STATUS_W-1:0]  res_status;
  logic [POS_W-1:0]     res_x, res_y;
  logic                 out_free;
  logic                 in_fire;
  logic [1:0]           grp;
  logic [SAMPLE_W-1:0]  xs, ys;
  axis_ctl_t            actl;
  axis_res_t            ares;
  sum_arr_t             eval_sums;

  assign in_ch.ready  = (state_r == S_IDLE) && !spare_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.x_pos  = out_x_r;
  assign out_ch.y_pos  = out_y_r;

  assign out_free = !out_valid_r || out_ch.ready;

  assign xs = in_ch.x_reply[REPLY_W-1:SHIFT];
  assign ys = in_ch.y_reply[REPLY_W-1:SHIFT];

  always_comb begin
    if (pair_count_r < GRP1_FIRST)      grp = 2'd0;
    else if (pair_count_r < GRP2_FIRST) grp = 2'd1;
    else                                grp = 2'd2;
  end

  assign eval_sums = (state_r == S_Y) ? y_sum_r : x_sum_r;

  tsmf_axis_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (actl),
    .sums  (eval_sums),
    .thr   (thr_r),
    .res   (ares)
  );

  always_comb begin
    state_nxt        = state_r;
    pair_count_nxt   = pair_count_r;
    x_sum_nxt        = x_sum_r;
    y_sum_nxt        = y_sum_r;
    x_keep_nxt       = x_keep_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_x_nxt        = out_x_r;
    out_y_nxt        = out_y_r;
    spare_valid_nxt  = spare_valid_r;
    spare_status_nxt = spare_status_r;
    spare_x_nxt      = spare_x_r;
    spare_y_nxt      = spare_y_r;
    res_push         = 1'b0;
    res_status       = ST_OK;
    res_x            = '0;
    res_y            = '0;
    actl.start       = 1'b0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          for (int g = 0; g < NUM_GROUPS; g++) begin
            if (grp == g[1:0]) begin
              x_sum_nxt[g] = x_sum_r[g] + {{(SUM_W-SAMPLE_W){1'b0}}, xs};
              y_sum_nxt[g] = y_sum_r[g] + {{(SUM_W-SAMPLE_W){1'b0}}, ys};
            end
          end
          pair_count_nxt = pair_count_r + 1'b1;
          if (pair_count_r == LAST_PAIR) begin
            actl.start = 1'b1;
            state_nxt  = S_X;
          end else if (!in_ch.pen_down) begin
            // early release: report and drop the partial point
            res_push       = 1'b1;
            res_status     = ST_PEN_UP;
            pair_count_nxt = '0;
            x_sum_nxt      = '0;
            y_sum_nxt      = '0;
          end
        end
      end
      S_X: begin
        if (ares.done) begin
          if (ares.reject) begin
            res_push       = 1'b1;
            res_status     = ST_X_BAD;
            pair_count_nxt = '0;
            x_sum_nxt      = '0;
            y_sum_nxt      = '0;
            state_nxt      = S_IDLE;
          end else begin
            x_keep_nxt = ares.pos;
            actl.start = 1'b1;
            state_nxt  = S_Y;
          end
        end
      end
      S_Y: begin
        if (ares.done) begin
          res_push       = 1'b1;
          res_status     = ares.reject ? ST_Y_BAD : ST_OK;
          res_x          = ares.reject ? '0 : x_keep_r;
          res_y          = ares.reject ? '0 : ares.pos;
          pair_count_nxt = '0;
          x_sum_nxt      = '0;
          y_sum_nxt      = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // advance the spare result first, then place a new one in the first free slot
    if (spare_valid_r && out_free) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = spare_status_r;
      out_x_nxt       = spare_x_r;
      out_y_nxt       = spare_y_r;
      spare_valid_nxt = 1'b0;
    end
    if (res_push) begin
      if (out_free && !spare_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status;
        out_x_nxt      = res_x;
        out_y_nxt      = res_y;
      end else begin
        spare_valid_nxt  = 1'b1;
        spare_status_nxt = res_status;
        spare_x_nxt      = res_x;
        spare_y_nxt      = res_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pair_count_r  <= '0;
      x_sum_r       <= '0;
      y_sum_r       <= '0;
      thr_r         <= THR_RESET;
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pair_count_r  <= pair_count_nxt;
      x_sum_r       <= x_sum_nxt;
      y_sum_r       <= y_sum_nxt;
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) thr_r <= cfg_ch.reject_threshold;
    end
  end

  always_ff @(posedge clk) begin
    x_keep_r       <= x_keep_nxt;
    out_status_r   <= out_status_nxt;
    out_x_r        <= out_x_nxt;
    out_y_r        <= out_y_nxt;
    spare_status_r <= spare_status_nxt;
    spare_x_r      <= spare_x_nxt;
    spare_y_r      <= spare_y_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) || (pair_count_r <= LAST_PAIR))
    else $error("pair count ran past the ninth pair");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("nonzero position on a failed point");

  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ares.done |-> (state_r == S_X || state_r == S_Y))
    else $error("evaluator finished outside a decision");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (pair_count_r == '0 && x_sum_r == '0 && y_sum_r == '0))
    else $error("point state not cleared after a result");

  a_spare_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !spare_valid_r)
    else $error("new result while the spare register is full");

endmodule
`default_nettype wire

// ----- verif/tsmf_point_checker.sv -----
// Channel monitor that predicts each touch point result and compares it with the filter output.
module tsmf_point_checker (
  input  logic clk,
  input  logic rst_n,
  tsmf_in_if   in_mon,
  tsmf_out_if  out_mon,
  tsmf_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count
);
  import tsmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    x_pos;
    logic [POS_W-1:0]    y_pos;
  } point_result_t;

  point_result_t      expected_points[$];
  logic [THR_W-1:0]   threshold;
  logic [COUNT_W-1:0] pairs_taken;
  logic [SUM_W-1:0]   x_sums [NUM_GROUPS];
  logic [SUM_W-1:0]   y_sums [NUM_GROUPS];
  int                 fails = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Returns 1 when all three mean spreads exceed the threshold; pos holds the picked average.
  function automatic logic axis_verdict(input logic [SUM_W-1:0] s0, s1, s2,
                                        input logic [THR_W-1:0] thr,
                                        output logic [POS_W-1:0] pos);
    logic [MEAN_W-1:0] g0, g1, g2, d01, d12, d20;
    logic [MEAN_W:0]   pair_sum;
    g0  = MEAN_W'(s0 / 3);
    g1  = MEAN_W'(s1 / 3);
    g2  = MEAN_W'(s2 / 3);
    d01 = (g0 > g1) ? g0 - g1 : g1 - g0;
    d12 = (g1 > g2) ? g1 - g2 : g2 - g1;
    d20 = (g2 > g0) ? g2 - g0 : g0 - g2;
    // strict compares: ties fall through in this order
    if (d01 < d12) begin
      if (d20 < d01) pair_sum = g0 + g2;
      else pair_sum = g0 + g1;
    end else if (d20 < d12) begin
      pair_sum = g0 + g2;
    end else begin
      pair_sum = g1 + g2;
    end
    pos = pair_sum[POS_W:1];
    return (d01 > thr) && (d12 > thr) && (d20 > thr);
  endfunction

  task automatic clear_point();
    pairs_taken = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      x_sums[g] = '0;
      y_sums[g] = '0;
    end
  endtask

  task automatic absorb_pair(input logic [REPLY_W-1:0] x, y, input logic pen);
    logic [SAMPLE_W-1:0] xs, ys;
    logic [POS_W-1:0]    xp, yp;
    logic                x_rej, y_rej;
    int                  grp;
    point_result_t       res;
    xs  = x[REPLY_W-1:SHIFT];
    ys  = y[REPLY_W-1:SHIFT];
    grp = (pairs_taken >= GRP2_FIRST) ? 2 : (pairs_taken >= GRP1_FIRST) ? 1 : 0;
    x_sums[grp] = x_sums[grp] + xs;
    y_sums[grp] = y_sums[grp] + ys;
    pairs_taken = pairs_taken + 1'b1;
    res.status = ST_OK;
    res.x_pos  = '0;
    res.y_pos  = '0;
    if (pairs_taken <= LAST_PAIR) begin
      if (pen) return;
      res.status = ST_PEN_UP;
    end else begin
      x_rej = axis_verdict(x_sums[0], x_sums[1], x_sums[2], threshold, xp);
      y_rej = axis_verdict(y_sums[0], y_sums[1], y_sums[2], threshold, yp);
      if (x_rej) begin
        res.status = ST_X_BAD;
      end else if (y_rej) begin
        res.status = ST_Y_BAD;
      end else begin
        res.x_pos = xp;
        res.y_pos = yp;
      end
    end
    clear_point();
    expected_points.push_back(res);
  endtask

  always @(posedge clk) begin
    point_result_t oldest;
    if (!rst_n) begin
      threshold = THR_RESET;
      clear_point();
      expected_points.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) threshold = cfg_mon.reject_threshold;
      if (in_mon.valid && in_mon.ready)
        absorb_pair(in_mon.x_reply, in_mon.y_reply, in_mon.pen_down);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: status %0d x_pos %0d y_pos %0d",
                 out_mon.status, out_mon.x_pos, out_mon.y_pos);
          fails++;
        end else begin
          oldest = expected_points.pop_front();
          if (out_mon.status !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d", oldest.status, out_mon.status);
            fails++;
          end
          if (out_mon.x_pos !== oldest.x_pos) begin
            $error("x_pos mismatch: expected %0d, actual %0d", oldest.x_pos, out_mon.x_pos);
            fails++;
          end
          if (out_mon.y_pos !== oldest.y_pos) begin
            $error("y_pos mismatch: expected %0d, actual %0d", oldest.y_pos, out_mon.y_pos);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    pending_count <= expected_points.size();
  end

endmodule

// ----- verif/tb.sv -----
// Top of the touch filter testbench: clock, reset, stimulus, output back-pressure and verdict.
module tb;
  import tsmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT      = 4000;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int NUM_PHASES      = 6;
  localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;

  logic clk = 1'b0;
  logic rst_n;

  tsmf_in_if  in_ch ();
  tsmf_out_if out_ch ();
  tsmf_cfg_if cfg_ch ();

  int               fail_count;
  int               pending_count;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               hold_req       = 0;
  int               hold_seen      = 0;
  int               hold_left      = 0;
  int               idle_cycles    = 0;
  int               sent_items     = 0;
  logic [THR_W-1:0] cur_thr        = THR_RESET;

  touch_sample_median_filter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tsmf_point_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial out_ch.ready = 1'b0;

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** touch_sample_median_filter: FAILED **");
      $finish;
    end
  end

  function automatic int clamp_sample(input int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  function automatic logic [REPLY_W-1:0] reply_of(input int sample);
    logic [SHIFT-1:0]    low_bits;
    logic [SAMPLE_W-1:0] s;
    low_bits = SHIFT'($urandom_range((1 << SHIFT) - 1));
    s        = SAMPLE_W'(sample);
    return {s, low_bits};
  endfunction

  // Spread between neighboring group means, biased to ties and the threshold edge.
  function automatic int pick_spread(input int thr);
    case ($urandom_range(5))
      0: return $urandom_range(2);
      1: return (thr > 0) ? thr - 1 : 0;
      2: return thr;
      3: return thr + 1;
      4: return $urandom_range(SAMPLE_MAX);
      default: return $urandom_range(40);
    endcase
  endfunction

  function automatic logic [NUM_GROUPS-1:0][SAMPLE_W-1:0] pick_group_means(input int thr);
    logic [NUM_GROUPS-1:0][SAMPLE_W-1:0] means;
    int m;
    int d;
    case ($urandom_range(3))
      0: m = 0;
      1: m = SAMPLE_MAX;
      default: m = $urandom_range(SAMPLE_MAX);
    endcase
    means[0] = SAMPLE_W'(m);
    for (int g = 1; g < NUM_GROUPS; g++) begin
      d = pick_spread(thr);
      if ($urandom_range(1)) m = m + d;
      else m = m - d;
      m        = clamp_sample(m);
      means[g] = SAMPLE_W'(m);
    end
    return means;
  endfunction

  task automatic send_pair(input logic [REPLY_W-1:0] x, y, input logic pen);
    in_ch.valid    <= 1'b1;
    in_ch.x_reply  <= x;
    in_ch.y_reply  <= y;
    in_ch.pen_down <= pen;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sent_items++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_point(input logic [NUM_GROUPS-1:0][SAMPLE_W-1:0] xm, ym,
                            input bit jitter, input logic last_pen);
    int xs;
    int ys;
    for (int p = 0; p < 9; p++) begin
      xs = int'(xm[p / 3]);
      ys = int'(ym[p / 3]);
      if (jitter && $urandom_range(2) == 0) begin
        xs = clamp_sample(xs + int'($urandom_range(4)) - 2);
        ys = clamp_sample(ys + int'($urandom_range(4)) - 2);
      end
      send_pair(reply_of(xs), reply_of(ys), (p == 8) ? last_pen : 1'b1);
    end
  endtask

  task automatic send_random_point();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // noise: random pen levels, end on a release to resync
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++)
        send_pair(REPLY_W'($urandom), REPLY_W'($urandom),
                  (k == n - 1) ? 1'b0 : 1'($urandom_range(1)));
    end else if (kind < 20) begin
      n = $urandom_range(7);
      for (int k = 0; k < n; k++) send_pair(REPLY_W'($urandom), REPLY_W'($urandom), 1'b1);
      send_pair(REPLY_W'($urandom), REPLY_W'($urandom), 1'b0);
    end else begin
      send_point(pick_group_means(int'(cur_thr)), pick_group_means(int'(cur_thr)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.reject_threshold <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    cur_thr = value;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    int               target;
    logic [THR_W-1:0] thr;
    int               s_pct;
    int               r_pct;
    bit               held;
    bit               drained;
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.x_reply           <= '0;
    in_ch.y_reply           <= '0;
    in_ch.pen_down          <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.reject_threshold <= '0;
    held    = 1'b0;
    drained = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset threshold
    send_pair('1, '1, 1'b0);
    send_point({13'd8191, 13'd100, 13'd0}, '0, 1'b0, 1'b0);
    send_point({3{13'd8191}}, {13'd200, 13'd50, 13'd0}, 1'b0, 1'b1);
    for (int k = 0; k < 3; k++) send_pair('0, '0, 1'b1);
    send_pair('0, '0, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0: begin thr = '0;                                s_pct = 0;  r_pct = 0;  end
        1: begin thr = '1;                                s_pct = 47; r_pct = 0;  end
        2: begin thr = THR_W'($urandom_range(1, 16));     s_pct = 0;  r_pct = 47; end
        3: begin thr = 13'd3;                             s_pct = 22; r_pct = 22; end
        4: begin thr = THR_W'($urandom_range(SAMPLE_MAX)); s_pct = 47; r_pct = 0; end
        default: begin thr = THR_RESET;                   s_pct = 0;  r_pct = 47; end
      endcase
      write_threshold(thr);
      send_idle_pct = s_pct;
      recv_stall_pct <= r_pct;
      target = sent_items + ITEMS_PER_PHASE;
      while (sent_items < target) begin
        if (p == 3 && !held && sent_items >= target - 150) begin
          // keep offering pairs while results are held back
          hold_req <= hold_req + 1;
          held = 1'b1;
        end
        if (p == 4 && !drained && sent_items >= target - 100) begin
          wait_for_results();
          drained = 1'b1;
        end
        send_random_point();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("** touch_sample_median_filter: PASSED **");
    else
      $display("** touch_sample_median_filter: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tsmf_pkg.sv
hw/rtl/tsmf_ifs.sv
hw/rtl/tsmf_axis_eval.sv
hw/rtl/touch_sample_median_filter.sv
verif/tsmf_point_checker.sv
verif/tb.sv
